@@ rtl/core/pvas_pkg.sv @@
// shared constants for the polygon vertex angular sort
// no dependencies
`default_nettype none

package pvas_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_COL = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/pvas_if.sv @@
// vertex and result channel interfaces, valid/ready handshake
// depends on pvas_pkg
`default_nettype none

interface pvas_vertex_if import pvas_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         final_point;

  modport source(output valid, pos_x, pos_y, final_point, input ready);
  modport sink(input valid, pos_x, pos_y, final_point, output ready);
endinterface

interface pvas_result_if import pvas_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [1:0]                   status;
  logic                         run_end;

  modport source(output valid, out_x, out_y, status, run_end, input ready);
  modport sink(input valid, out_x, out_y, status, run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pvas_ring_cell.sv @@
// one cell of the vertex ring: holds a vertex, rotates it to its neighbor
// and compares it with the probe vertex at the ring head; depends on pvas_pkg
`default_nettype none

module pvas_ring_cell import pvas_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load_en,
  input  logic                         shift_en,
  input  logic signed [COORD_BITS-1:0] din_x,
  input  logic signed [COORD_BITS-1:0] din_y,
  input  logic signed [COORD_BITS-1:0] nb_x,
  input  logic signed [COORD_BITS-1:0] nb_y,
  input  logic                         probe_en,
  input  logic signed [COORD_BITS-1:0] probe_x,
  input  logic signed [COORD_BITS-1:0] probe_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic                         hit
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      x <= din_x;
      y <= din_y;
    end else if (shift_en) begin
      x <= nb_x;
      y <= nb_y;
    end
  end

  assign hit = probe_en && (x == probe_x) && (y == probe_y);

endmodule

`default_nettype wire

@@ rtl/core/pvas_sort_cell.sv @@
// one cell of the insertion sort chain, ordered by polar angle
// about the lowest vertex; depends on pvas_pkg
`default_nettype none

module pvas_sort_cell import pvas_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ins_en,
  input  logic                         pop_en,
  input  logic signed [DW-1:0]         new_dx,
  input  logic signed [DW-1:0]         new_dy,
  input  logic signed [COORD_BITS-1:0] new_x,
  input  logic signed [COORD_BITS-1:0] new_y,
  input  logic                         prev_place,
  input  logic                         prev_valid,
  input  logic signed [DW-1:0]         prev_dx,
  input  logic signed [DW-1:0]         prev_dy,
  input  logic signed [COORD_BITS-1:0] prev_x,
  input  logic signed [COORD_BITS-1:0] prev_y,
  input  logic                         next_valid,
  input  logic signed [DW-1:0]         next_dx,
  input  logic signed [DW-1:0]         next_dy,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  output logic                         valid,
  output logic signed [DW-1:0]         dx,
  output logic signed [DW-1:0]         dy,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic                         place
);

  logic signed [PW-1:0] lhs;
  logic signed [PW-1:0] rhs;
  logic                 take_new;
  logic                 take_prev;

  // new word strictly ahead of the held one in angle, or the cell is empty
  assign lhs       = PW'(new_dx) * PW'(dy);
  assign rhs       = PW'(new_dy) * PW'(dx);
  assign place     = !valid || (lhs < rhs);
  assign take_new  = ins_en && place && !prev_place;
  assign take_prev = ins_en && place && prev_place;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_new) begin
      valid <= 1'b1;
    end else if (take_prev) begin
      valid <= prev_valid;
    end else if (pop_en) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      dx <= new_dx;
      dy <= new_dy;
      x  <= new_x;
      y  <= new_y;
    end else if (take_prev) begin
      dx <= prev_dx;
      dy <= prev_dy;
      x  <= prev_x;
      y  <= prev_y;
    end else if (pop_en) begin
      dx <= next_dx;
      dy <= next_dy;
      x  <= next_x;
      y  <= next_y;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/polygon_vertex_angular_sort.sv @@
// Vertices load one per cycle into a ring of MAX_POINTS cells. After the word
// marked final_point the input stalls while the ring head makes four passes
// over the n stored vertices, one vertex a cycle: duplicate search, collinear
// triple search (plus a drain of the multiplier pipeline), lowest point search,
// and insertion of the other vertices into a sorted cell chain. Sets under
// three vertices skip the collinear pass. Then the n results (or one error
// word) leave at one per cycle under result backpressure. Depends on pvas_pkg,
// pvas_if, pvas_ring_cell and pvas_sort_cell.
`default_nettype none

module polygon_vertex_angular_sort import pvas_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  pvas_vertex_if.sink    vertex,
  pvas_result_if.source  result
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SC = MAX_POINTS - 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_DUP  = 3'd1;
  localparam logic [2:0] S_COL  = 3'd2;
  localparam logic [2:0] S_LOW  = 3'd3;
  localparam logic [2:0] S_SORT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] n;
  logic [CW-1:0] step;
  logic [CW-1:0] emit_cnt;
  logic          dup_flag;
  logic          col_flag;
  logic [1:0]    err_code;

  logic signed [COORD_BITS-1:0] ring_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ring_y [MAX_POINTS];
  logic [MAX_POINTS-1:0]        hit;
  logic                         accept;
  logic                         issuing;
  logic                         rotate;

  logic signed [DW-1:0] c_ax, c_ay, c_bx, c_by;
  logic signed [PW-1:0] c_p, c_q;
  logic                 c_v1, c_v2;

  logic signed [COORD_BITS-1:0] best_x, best_y;
  logic [IW-1:0]                best_idx;

  logic                         ins_v;
  logic signed [DW-1:0]         ins_dx, ins_dy;
  logic signed [COORD_BITS-1:0] ins_x, ins_y;

  logic                         s_valid [SC];
  logic signed [DW-1:0]         s_dx    [SC];
  logic signed [DW-1:0]         s_dy    [SC];
  logic signed [COORD_BITS-1:0] s_x     [SC];
  logic signed [COORD_BITS-1:0] s_y     [SC];
  logic                         s_place [SC];

  logic                         res_valid;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic [1:0]                   res_status;
  logic                         res_end;
  logic                         out_free;
  logic                         pop_en;

  assign vertex.ready = (state == S_LOAD);
  assign accept       = vertex.valid && vertex.ready;
  assign issuing      = (step < n);
  assign rotate       = issuing && ((state == S_DUP) || (state == S_COL) ||
                                    (state == S_LOW) || (state == S_SORT));
  assign out_free     = !res_valid || result.ready;
  assign pop_en       = (state == S_EMIT) && out_free && (emit_cnt != '0);

  // vertex ring
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
    logic signed [COORD_BITS-1:0] nbx, nby;
    logic                         pen;
    assign nbx = (CW'(k + 1) == n) ? ring_x[0] : ring_x[(k + 1) % MAX_POINTS];
    assign nby = (CW'(k + 1) == n) ? ring_y[0] : ring_y[(k + 1) % MAX_POINTS];
    assign pen = (k != 0) && (state == S_DUP) && issuing && (CW'(k) < n);

    pvas_ring_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk      (clk),
      .load_en  (accept && (cnt == CW'(k))),
      .shift_en (rotate),
      .din_x    (vertex.pos_x),
      .din_y    (vertex.pos_y),
      .nb_x     (nbx),
      .nb_y     (nby),
      .probe_en (pen),
      .probe_x  (ring_x[0]),
      .probe_y  (ring_y[0]),
      .x        (ring_x[k]),
      .y        (ring_y[k]),
      .hit      (hit[k])
    );
  end

  // sort chain
  for (genvar k = 0; k < SC; k++) begin : g_sort
    logic                         pv, pp, nv;
    logic signed [DW-1:0]         pdx, pdy, ndx, ndy;
    logic signed [COORD_BITS-1:0] px, py, nx, ny;
    if (k == 0) begin : g_first
      assign pp = 1'b0;
      assign pv = 1'b0;
      assign pdx = '0;
      assign pdy = '0;
      assign px = '0;
      assign py = '0;
    end else begin : g_mid
      assign pp = s_place[k-1];
      assign pv = s_valid[k-1];
      assign pdx = s_dx[k-1];
      assign pdy = s_dy[k-1];
      assign px = s_x[k-1];
      assign py = s_y[k-1];
    end
    if (k == SC - 1) begin : g_last
      assign nv = 1'b0;
      assign ndx = '0;
      assign ndy = '0;
      assign nx = '0;
      assign ny = '0;
    end else begin : g_inner
      assign nv = s_valid[k+1];
      assign ndx = s_dx[k+1];
      assign ndy = s_dy[k+1];
      assign nx = s_x[k+1];
      assign ny = s_y[k+1];
    end

    pvas_sort_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ins_en     (ins_v),
      .pop_en     (pop_en),
      .new_dx     (ins_dx),
      .new_dy     (ins_dy),
      .new_x      (ins_x),
      .new_y      (ins_y),
      .prev_place (pp),
      .prev_valid (pv),
      .prev_dx    (pdx),
      .prev_dy    (pdy),
      .prev_x     (px),
      .prev_y     (py),
      .next_valid (nv),
      .next_dx    (ndx),
      .next_dy    (ndy),
      .next_x     (nx),
      .next_y     (ny),
      .valid      (s_valid[k]),
      .dx         (s_dx[k]),
      .dy         (s_dy[k]),
      .x          (s_x[k]),
      .y          (s_y[k]),
      .place      (s_place[k])
    );
  end

  // collinear test pipeline at the ring head
  always_ff @(posedge clk) begin
    c_ax <= DW'(ring_x[2]) - DW'(ring_x[0]);
    c_ay <= DW'(ring_y[2]) - DW'(ring_y[0]);
    c_bx <= DW'(ring_x[1]) - DW'(ring_x[0]);
    c_by <= DW'(ring_y[1]) - DW'(ring_y[0]);
    c_p  <= PW'(c_ax) * PW'(c_by);
    c_q  <= PW'(c_ay) * PW'(c_bx);
  end

  // insert stage
  always_ff @(posedge clk) begin
    ins_dx <= DW'(ring_x[0]) - DW'(best_x);
    ins_dy <= DW'(ring_y[0]) - DW'(best_y);
    ins_x  <= ring_x[0];
    ins_y  <= ring_y[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      n         <= '0;
      step      <= '0;
      emit_cnt  <= '0;
      dup_flag  <= 1'b0;
      col_flag  <= 1'b0;
      err_code  <= ST_OK;
      c_v1      <= 1'b0;
      c_v2      <= 1'b0;
      ins_v     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      c_v1  <= (state == S_COL) && issuing;
      c_v2  <= c_v1;
      ins_v <= (state == S_SORT) && issuing && (step[IW-1:0] != best_idx);
      if (c_v2 && (c_p == c_q)) begin
        col_flag <= 1'b1;
      end
      if (out_free) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (vertex.final_point) begin
              n        <= (cnt < CW'(MAX_POINTS)) ? cnt + 1'b1 : cnt;
              cnt      <= '0;
              step     <= '0;
              dup_flag <= 1'b0;
              col_flag <= 1'b0;
              state    <= S_DUP;
            end else if (cnt < CW'(MAX_POINTS)) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DUP: begin
          if (issuing) begin
            step <= step + 1'b1;
            if (|hit) begin
              dup_flag <= 1'b1;
            end
          end else begin
            step <= '0;
            if (dup_flag) begin
              err_code <= ST_DUP;
              state    <= S_ERR;
            end else if (n >= CW'(3)) begin
              state <= S_COL;
            end else begin
              state <= S_LOW;
            end
          end
        end
        S_COL: begin
          if (issuing) begin
            step <= step + 1'b1;
          end else if (!c_v1 && !c_v2) begin
            step <= '0;
            if (col_flag) begin
              err_code <= ST_COL;
              state    <= S_ERR;
            end else begin
              state <= S_LOW;
            end
          end
        end
        S_LOW: begin
          if (issuing) begin
            step <= step + 1'b1;
            if ((step == '0) || (ring_y[0] < best_y) ||
                ((ring_y[0] == best_y) && (ring_x[0] < best_x))) begin
              best_x   <= ring_x[0];
              best_y   <= ring_y[0];
              best_idx <= step[IW-1:0];
            end
          end else begin
            step  <= '0;
            state <= S_SORT;
          end
        end
        S_SORT: begin
          if (issuing) begin
            step <= step + 1'b1;
          end else begin
            step     <= '0;
            emit_cnt <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_status <= ST_OK;
            res_end    <= (emit_cnt == n - 1'b1);
            if (emit_cnt == '0) begin
              res_x <= best_x;
              res_y <= best_y;
            end else begin
              res_x <= s_x[0];
              res_y <= s_y[0];
            end
            emit_cnt <= emit_cnt + 1'b1;
            if (emit_cnt == n - 1'b1) begin
              state <= S_LOAD;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_x      <= '0;
            res_y      <= '0;
            res_status <= err_code;
            res_end    <= 1'b1;
            state      <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign result.valid   = res_valid;
  assign result.out_x   = res_x;
  assign result.out_y   = res_y;
  assign result.status  = res_status;
  assign result.run_end = res_end;

  a_chain_room: assert property (@(posedge clk) disable iff (rst)
    ins_v |-> !s_valid[SC-1])
    else $error("insert into full sort chain");

  a_chain_empty: assert property (@(posedge clk) disable iff (rst)
    vertex.ready |-> !s_valid[0])
    else $error("sort chain not drained before loading");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != ST_OK)) |-> result.run_end)
    else $error("error word without run end");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(MAX_POINTS)) && (n <= CW'(MAX_POINTS)))
    else $error("vertex count out of range");

endmodule

`default_nettype wire
